/* hw/rtl/rrbm_pkg.sv */
// Package for the cartridge bank mapper: address region codes, window
// constants and bank-number helpers. No dependencies.
package rrbm_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned MAP_W    = 21;
    localparam int unsigned BANK_W   = 7;
    localparam int unsigned RBANK_W  = 2;
    localparam int unsigned ROM_OFS_W = 14;  // 0x4000 window
    localparam int unsigned RAM_OFS_W = 13;  // 0x2000 window

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    // Address regions, decoded from bus_address[15:13]
    typedef enum logic [2:0] {
        RGN_RAM_EN  = 3'd0,  // 0x0000-0x1FFF
        RGN_BANK_LO = 3'd1,  // 0x2000-0x3FFF
        RGN_BANK_HI = 3'd2,  // 0x4000-0x5FFF
        RGN_MODE    = 3'd3,  // 0x6000-0x7FFF
        RGN_VRAM    = 3'd4,  // 0x8000-0x9FFF
        RGN_RAM     = 3'd5,  // 0xA000-0xBFFF
        RGN_HI0     = 3'd6,
        RGN_HI1     = 3'd7
    } t_region;

    function automatic logic [BANK_W-1:0] rom_bank(input logic [BANK_W-1:0] sel,
                                                    input logic rom_banking);
        logic [BANK_W-1:0] b;
        b = rom_banking ? sel : {2'b00, sel[4:0]};
        if (b[4:0] == 5'd0) begin
            b = b + 7'd1;
        end
        return b;
    endfunction

    function automatic logic [RBANK_W-1:0] ram_bank(input logic [BANK_W-1:0] sel,
                                                     input logic rom_banking);
        return rom_banking ? 2'd0 : sel[6:5];
    endfunction

endpackage

/* hw/rtl/rom_ram_bank_mapper_top.sv */
// Cartridge bank mapper top level: input register, decode and control state,
// result register. Depends on rrbm_pkg.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | i_in_valid / o_in_stall    | i_cmd, i_bus_address, i_write_byte
//  out     | from block| o_out_valid / i_out_stall  | o_hit, o_mapped_address, o_is_rom
//
// One word per cycle while the output is not stalled; two register stages (input
// register, then result register): a word accepted into the input register is
// decoded into the result register; only the address decode lies between them.
// Reset: RAM disabled, ROM banking mode, bank select 0, both stages empty.
// A stalled result holds; the input register still fills behind it, and
// o_in_stall rises only when both stages are full and the output is stalled.
module rom_ram_bank_mapper_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_cmd,
    input  logic [rrbm_pkg::ADDR_W-1:0]    i_bus_address,
    input  logic [rrbm_pkg::DATA_W-1:0]    i_write_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_hit,
    output logic [rrbm_pkg::MAP_W-1:0]     o_mapped_address,
    output logic                           o_is_rom
);
    import rrbm_pkg::*;

    logic                r_in_valid;
    t_cmd                r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic [DATA_W-1:0]   r_data;

    logic                r_ram_en;
    logic                r_rom_banking;
    logic [BANK_W-1:0]   r_bank_sel;

    logic                r_out_valid;
    logic                r_hit;
    logic [MAP_W-1:0]    r_mapped;
    logic                r_is_rom;

    logic                n_ram_en;
    logic                n_rom_banking;
    logic [BANK_W-1:0]   n_bank_sel;
    logic                n_hit;
    logic [MAP_W-1:0]    n_mapped;
    logic                n_is_rom;

    logic                out_ready;
    logic                advance;
    logic                in_take;
    t_region             rgn;
    logic [MAP_W-1:0]    ram_addr;
    logic [MAP_W-1:0]    rom_addr;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    assign rgn = t_region'(r_addr[ADDR_W-1 -: 3]);

    assign rom_addr = {rom_bank(r_bank_sel, r_rom_banking), r_addr[ROM_OFS_W-1:0]};
    assign ram_addr = MAP_W'(r_addr)
                    + {{(MAP_W-RBANK_W-RAM_OFS_W){1'b0}},
                       ram_bank(r_bank_sel, r_rom_banking), {RAM_OFS_W{1'b0}}};

    always_comb begin
        n_ram_en      = r_ram_en;
        n_rom_banking = r_rom_banking;
        n_bank_sel    = r_bank_sel;
        n_hit         = 1'b0;
        n_mapped      = '0;
        n_is_rom      = 1'b0;
        if (r_cmd == CMD_READ) begin
            unique case (rgn)
                RGN_RAM_EN, RGN_BANK_LO: begin
                    n_hit    = 1'b1;
                    n_is_rom = 1'b1;
                    n_mapped = MAP_W'(r_addr);
                end
                RGN_BANK_HI, RGN_MODE: begin
                    n_hit    = 1'b1;
                    n_is_rom = 1'b1;
                    n_mapped = rom_addr;
                end
                RGN_RAM: begin
                    if (r_ram_en) begin
                        n_hit    = 1'b1;
                        n_mapped = ram_addr;
                    end
                end
                default: ;
            endcase
        end else begin
            unique case (rgn)
                RGN_RAM_EN:  n_ram_en = (r_data[3:0] == RAM_EN_KEY);
                RGN_BANK_LO: n_bank_sel = {r_bank_sel[6:5], r_data[4:0]};
                RGN_BANK_HI: n_bank_sel = {r_data[1:0], r_bank_sel[4:0]};
                RGN_MODE:    n_rom_banking = !r_data[0];
                RGN_RAM: begin
                    n_hit    = 1'b1;
                    n_mapped = ram_addr;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ram_en      <= 1'b0;
            r_rom_banking <= 1'b1;
            r_bank_sel    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_ram_en      <= n_ram_en;
                r_rom_banking <= n_rom_banking;
                r_bank_sel    <= n_bank_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_addr <= i_bus_address;
            r_data <= i_write_byte;
        end
        if (advance) begin
            r_hit    <= n_hit;
            r_mapped <= n_mapped;
            r_is_rom <= n_is_rom;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_hit;
    assign o_mapped_address = r_mapped;
    assign o_is_rom         = r_is_rom;

    a_rom_implies_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_is_rom |-> r_hit)
        else $error("ROM flag without hit");

    a_miss_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_hit |-> r_mapped == '0)
        else $error("miss with nonzero mapped address");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_ready |=> r_in_valid && $stable(r_addr))
        else $error("input word lost while output stalled");

    a_reset_mode: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_rom_banking && !r_ram_en && r_bank_sel == '0)
        else $error("control state not at reset value");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_bank_sel) && $stable(r_rom_banking) && $stable(r_ram_en))
        else $error("control state changed without a word");

endmodule
